>>> design/epbf_pkg.sv
`timescale 1ns / 1ps
package epbf_pkg;

   localparam int MAX_IMAGE_SIDE_DEFAULT = 8192;
   localparam int CORDIC_STAGES_DEFAULT  = 18;

   // One square-root cell per result bit of a 64-bit radicand.
   localparam int SQRT_STEPS = 32;

   // CORDIC datapath width: 33-bit operands scaled by 2^24 plus gain headroom.
   localparam int CX_W = 60;

   // Width of the box edges and of the wrap remainders.
   localparam int BOX_W = 24;
   // The narrowest nonzero image gives 512 half-steps of 1/512 pixel, so this many
   // restoring steps reduce any BOX_W-bit edge below the doubled width.
   localparam int MOD_STEPS = BOX_W - 9;

   localparam logic [31:0] ATAN_TURNS [0:31] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

   typedef enum logic [2:0] {
      CSR_YAW_OFFSET   = 3'd0,
      CSR_FLIP_MODE    = 3'd1,
      CSR_IMAGE_WIDTH  = 3'd2,
      CSR_IMAGE_HEIGHT = 3'd3,
      CSR_BOX_CENTER_X = 3'd4,
      CSR_BOX_CENTER_Y = 3'd5,
      CSR_BOX_WIDTH    = 3'd6,
      CSR_BOX_HEIGHT   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   // Remainders of the horizontal box edges modulo the doubled image width.
   typedef struct packed {
      logic [BOX_W-1:0] left_mag;
      logic [BOX_W-1:0] span;
      logic [BOX_W-1:0] right;
   } box_rem_type;

endpackage

>>> design/equirect_point_box_filter_unit.sv
`timescale 1ns / 1ps
// Projects one camera-frame point per clock onto an equirectangular image and
// tests it against a detection box. A point is taken whenever start is high and
// busy is low, and its result appears on the rsp_ ports with rsp_strobe; the
// result is shown for one cycle only, since the receiver cannot stall. The
// pipeline holds, in order: the input register at the accepting edge, the
// absolute values, the squares and their sum, 32 square-root cells, the CORDIC
// setup register, CORDIC_STAGES CORDIC cells for longitude and latitude side by
// side, and the turn fractions, scaled pixels, flipped pixels with the image
// test, and the box test. After reset and after every register write, busy is
// high while a remainder unit reduces the box edges modulo the image width.
module equirect_point_box_filter_unit #(
   parameter int MAX_IMAGE_SIDE = epbf_pkg::MAX_IMAGE_SIDE_DEFAULT,
   parameter int CORDIC_STAGES  = epbf_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic               rsp_strobe,
   output logic               rsp_keep,
   output logic               rsp_in_image,
   output logic [20:0]        rsp_u_pixel,
   output logic [20:0]        rsp_v_pixel,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [21:0]        csr_write_data
);

   localparam int W_W    = $clog2(MAX_IMAGE_SIDE + 1);
   localparam int U_W    = W_W + 8;
   localparam int W2_W   = W_W + 9;
   localparam int BW     = epbf_pkg::BOX_W;
   localparam int XW     = (W2_W > BW) ? W2_W : BW;
   localparam int CMP_W  = XW + 2;
   localparam int CX_W   = epbf_pkg::CX_W;
   localparam int N      = CORDIC_STAGES;
   localparam int SQ     = epbf_pkg::SQRT_STEPS;
   localparam int S_INIT = SQ + 4;
   localparam int LAST   = S_INIT + N + 4;

   // Configuration registers.
   logic [15:0] yaw_ff;
   logic [1:0]  flip_ff;
   logic [13:0] imw_ff, imh_ff;
   logic [20:0] bcx_ff, bcy_ff;
   logic [21:0] bw_ff, bh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff  <= '0;
         flip_ff <= '0;
         imw_ff  <= 14'd1920;
         imh_ff  <= 14'd960;
         bcx_ff  <= '0;
         bcy_ff  <= '0;
         bw_ff   <= '0;
         bh_ff   <= '0;
      end else if (csr_write_enable) begin
         case (epbf_pkg::csr_index_type'(csr_index))
            epbf_pkg::CSR_YAW_OFFSET:   yaw_ff  <= csr_write_data[15:0];
            epbf_pkg::CSR_FLIP_MODE:    flip_ff <= csr_write_data[1:0];
            epbf_pkg::CSR_IMAGE_WIDTH:  imw_ff  <= csr_write_data[13:0];
            epbf_pkg::CSR_IMAGE_HEIGHT: imh_ff  <= csr_write_data[13:0];
            epbf_pkg::CSR_BOX_CENTER_X: bcx_ff  <= csr_write_data[20:0];
            epbf_pkg::CSR_BOX_CENTER_Y: bcy_ff  <= csr_write_data[20:0];
            epbf_pkg::CSR_BOX_WIDTH:    bw_ff   <= csr_write_data[21:0];
            epbf_pkg::CSR_BOX_HEIGHT:   bh_ff   <= csr_write_data[21:0];
            default: begin
            end
         endcase
      end
   end

   logic [W_W-1:0] w_c, h_c;
   assign w_c = (32'(imw_ff) > 32'(MAX_IMAGE_SIDE)) ? W_W'(MAX_IMAGE_SIDE) : W_W'(imw_ff);
   assign h_c = (32'(imh_ff) > 32'(MAX_IMAGE_SIDE)) ? W_W'(MAX_IMAGE_SIDE) : W_W'(imh_ff);

   // Box edges at 1/512 pixel, taken from the registers.
   logic signed [CMP_W-1:0] x0_c, x1_c, y0_c, y1_c, w2_c;
   assign x0_c = (CMP_W'(bcx_ff) << 1) - CMP_W'(bw_ff);
   assign x1_c = (CMP_W'(bcx_ff) << 1) + CMP_W'(bw_ff);
   assign y0_c = (CMP_W'(bcy_ff) << 1) - CMP_W'(bh_ff);
   assign y1_c = (CMP_W'(bcy_ff) << 1) + CMP_W'(bh_ff);
   assign w2_c = CMP_W'({w_c, 9'd0});

   epbf_pkg::box_rem_type rem;
   logic [BW-1:0] left_mag_c, span_c, right_c;
   assign left_mag_c = BW'(x0_c[CMP_W-1] ? -x0_c : x0_c);
   assign span_c     = BW'(CMP_W'(bw_ff) << 1);
   assign right_c    = BW'(x1_c);

   epbf_box_setup #(.W2_W(W2_W)) u_setup (
      .clock    (clock),
      .reset    (reset),
      .start    (csr_write_enable),
      .left_mag (left_mag_c),
      .span     (span_c),
      .right    (right_c),
      .width2   ({w_c, 9'd0}),
      .rem      (rem),
      .busy     (busy)
   );

   // Left edge raised into the image and right edge modulo the doubled width.
   logic signed [CMP_W-1:0] rem_a, rem_b, rem_c, x0_wrap, x1_sum, x1_wrap, x0_s, x1_m;
   logic simple_c;
   assign rem_a    = CMP_W'(rem.left_mag);
   assign rem_b    = CMP_W'(rem.span);
   assign rem_c    = CMP_W'(rem.right);
   assign x0_wrap  = (rem_a == '0) ? '0 : w2_c - rem_a;
   assign x1_sum   = x0_wrap + rem_b;
   assign x1_wrap  = (x1_sum >= w2_c) ? x1_sum - w2_c : x1_sum;
   assign x0_s     = x0_c[CMP_W-1] ? x0_wrap : x0_c;
   assign x1_m     = x0_c[CMP_W-1] ? x1_wrap : rem_c;
   assign simple_c = !x0_c[CMP_W-1] && (x1_c < w2_c);

   // Valid bits and the point carried alongside the pipeline.
   logic [LAST:0] vld_ff;
   epbf_pkg::point_type pt_ff [0:LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAST-1:0], start & ~busy};
      end
   end

   always_ff @(posedge clock) begin
      pt_ff[0] <= '{x: req_point_x, y: req_point_y, z: req_point_z};
      for (int s = 1; s <= LAST; s++) begin
         pt_ff[s] <= pt_ff[s-1];
      end
   end

   // Lateral radius squared.
   logic [31:0] ax_ff, az_ff;
   logic [63:0] sqx_ff, sqz_ff, n_ff;

   always_ff @(posedge clock) begin
      ax_ff  <= pt_ff[0].x[31] ? 32'(-pt_ff[0].x) : 32'(pt_ff[0].x);
      az_ff  <= pt_ff[0].z[31] ? 32'(-pt_ff[0].z) : 32'(pt_ff[0].z);
      sqx_ff <= ax_ff * ax_ff;
      sqz_ff <= az_ff * az_ff;
      n_ff   <= sqx_ff + sqz_ff;
   end

   logic [63:0] sq_n [0:SQ];
   logic [63:0] sq_r [0:SQ];
   assign sq_n[0] = n_ff;
   assign sq_r[0] = 64'd0;

   for (genvar j = 0; j < SQ; j++) begin : g_sqrt
      epbf_sqrt_cell #(.BIT_POS(62 - 2 * j)) u_cell (
         .clock (clock),
         .n_i   (sq_n[j]),
         .res_i (sq_r[j]),
         .n_o   (sq_n[j+1]),
         .res_o (sq_r[j+1])
      );
   end

   // CORDIC setup: a negative denominator turns the vector by half a turn.
   logic signed [CX_W-1:0] lon_x0_ff, lon_y0_ff, lat_x0_ff, lat_y0_ff;
   logic [31:0] lon_z0_ff;

   always_ff @(posedge clock) begin
      if (pt_ff[S_INIT-1].z[31]) begin
         lon_x0_ff <= -(CX_W'(pt_ff[S_INIT-1].z) <<< 24);
         lon_y0_ff <= -(CX_W'(pt_ff[S_INIT-1].x) <<< 24);
         lon_z0_ff <= 32'h8000_0000;
      end else begin
         lon_x0_ff <= CX_W'(pt_ff[S_INIT-1].z) <<< 24;
         lon_y0_ff <= CX_W'(pt_ff[S_INIT-1].x) <<< 24;
         lon_z0_ff <= 32'd0;
      end
      lat_x0_ff <= CX_W'({1'b0, sq_r[SQ]}) <<< 24;
      lat_y0_ff <= CX_W'(pt_ff[S_INIT-1].y) <<< 24;
   end

   logic signed [CX_W-1:0] lon_x [0:N], lon_y [0:N], lat_x [0:N], lat_y [0:N];
   logic [31:0] lon_z [0:N], lat_z [0:N];
   assign lon_x[0] = lon_x0_ff;
   assign lon_y[0] = lon_y0_ff;
   assign lon_z[0] = lon_z0_ff;
   assign lat_x[0] = lat_x0_ff;
   assign lat_y[0] = lat_y0_ff;
   assign lat_z[0] = 32'd0;

   for (genvar j = 0; j < N; j++) begin : g_cordic
      epbf_cordic_cell #(.SHIFT(j)) u_lon (
         .clock (clock),
         .x_i (lon_x[j]), .y_i (lon_y[j]), .z_i (lon_z[j]),
         .x_o (lon_x[j+1]), .y_o (lon_y[j+1]), .z_o (lon_z[j+1])
      );
      epbf_cordic_cell #(.SHIFT(j)) u_lat (
         .clock (clock),
         .x_i (lat_x[j]), .y_i (lat_y[j]), .z_i (lat_z[j]),
         .x_o (lat_x[j+1]), .y_o (lat_y[j+1]), .z_o (lat_z[j+1])
      );
   end

   // Turn fractions for the two axes.
   logic [31:0] p_in, p_ff;
   logic [32:0] q_in, q_ff;

   always_comb begin
      logic lon_zero, lat_zero;
      logic [31:0] lon, lat;
      logic signed [34:0] qs;
      lon_zero = (pt_ff[S_INIT+N].x == '0) && (pt_ff[S_INIT+N].z == '0);
      lat_zero = lon_zero && (pt_ff[S_INIT+N].y == '0);
      lon  = lon_zero ? 32'd0 : lon_z[N] + {yaw_ff, 16'd0};
      p_in = lon ^ 32'h8000_0000;
      lat  = lat_zero ? 32'd0 : lat_z[N];
      qs   = 35'sd2147483648 - (35'(signed'(lat)) <<< 1);
      if (qs[34]) begin
         q_in = '0;
      end else if (qs > 35'sd4294967296) begin
         q_in = 33'h1_0000_0000;
      end else begin
         q_in = qs[32:0];
      end
   end

   logic [32+W_W-1:0] u_prod;
   logic [33+W_W-1:0] v_prod;
   logic [U_W-1:0] u8_ff, v8_ff, uf_ff, vf_ff, u_flip, v_flip, wpix, hpix;
   logic img_ff;

   assign u_prod = p_ff * w_c;
   assign v_prod = q_ff * h_c;
   assign wpix   = {w_c, 8'd0};
   assign hpix   = {h_c, 8'd0};
   assign u_flip = flip_ff[0] ? wpix - u8_ff : u8_ff;
   assign v_flip = flip_ff[1] ? hpix - v8_ff : v8_ff;

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      q_ff   <= q_in;
      u8_ff  <= u_prod[24 +: U_W];
      v8_ff  <= v_prod[24 +: U_W];
      uf_ff  <= u_flip;
      vf_ff  <= v_flip;
      img_ff <= (u_flip < wpix) && (v_flip < hpix);
   end

   // Box test at 1/512 pixel; the horizontal span may wrap over the seam.
   logic signed [CMP_W-1:0] u2s, v2s;
   logic vert_ok, horiz_ok;
   logic [31:0] u_ext, v_ext;

   assign u2s = CMP_W'({uf_ff, 1'b0});
   assign v2s = CMP_W'({vf_ff, 1'b0});
   assign vert_ok = (v2s >= y0_c) && (v2s <= y1_c);
   assign horiz_ok = (w2_c == '0) ? 1'b0 :
                     simple_c ? ((u2s >= x0_c) && (u2s <= x1_c)) :
                     (((u2s >= x0_s) && (u2s < w2_c)) || (u2s <= x1_m));
   assign u_ext = 32'(uf_ff);
   assign v_ext = 32'(vf_ff);

   logic keep_ff, in_image_ff;
   logic [20:0] u_pix_ff, v_pix_ff;

   always_ff @(posedge clock) begin
      keep_ff     <= img_ff && vert_ok && horiz_ok;
      in_image_ff <= img_ff;
      u_pix_ff    <= (u_ext > 32'd2097151) ? 21'h1F_FFFF : u_ext[20:0];
      v_pix_ff    <= (v_ext > 32'd2097151) ? 21'h1F_FFFF : v_ext[20:0];
   end

   assign rsp_strobe   = vld_ff[LAST];
   assign rsp_keep     = keep_ff;
   assign rsp_in_image = in_image_ff;
   assign rsp_u_pixel  = u_pix_ff;
   assign rsp_v_pixel  = v_pix_ff;
   assign rsp_out_x    = pt_ff[LAST].x;
   assign rsp_out_y    = pt_ff[LAST].y;
   assign rsp_out_z    = pt_ff[LAST].z;

endmodule

>>> design/epbf_sqrt_cell.sv
`timescale 1ns / 1ps
module epbf_sqrt_cell #(
   parameter int BIT_POS = 62
) (
   input  logic        clock,
   input  logic [63:0] n_i,
   input  logic [63:0] res_i,
   output logic [63:0] n_o,
   output logic [63:0] res_o
);

   logic [63:0] n_in, res_in, n_ff, res_ff;

   always_comb begin
      logic [63:0] bit_v, trial;
      bit_v = 64'd1 << BIT_POS;
      trial = res_i + bit_v;
      if (n_i >= trial) begin
         n_in   = n_i - trial;
         res_in = (res_i >> 1) + bit_v;
      end else begin
         n_in   = n_i;
         res_in = res_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      res_ff <= res_in;
   end

   assign n_o   = n_ff;
   assign res_o = res_ff;

endmodule

>>> design/epbf_cordic_cell.sv
`timescale 1ns / 1ps
module epbf_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                              clock,
   input  logic signed [epbf_pkg::CX_W-1:0]  x_i,
   input  logic signed [epbf_pkg::CX_W-1:0]  y_i,
   input  logic        [31:0]                z_i,
   output logic signed [epbf_pkg::CX_W-1:0]  x_o,
   output logic signed [epbf_pkg::CX_W-1:0]  y_o,
   output logic        [31:0]                z_o
);

   logic signed [epbf_pkg::CX_W-1:0] x_in, y_in, x_ff, y_ff;
   logic [31:0] z_in, z_ff;

   always_comb begin
      logic signed [epbf_pkg::CX_W-1:0] dx, dy;
      dx = y_i >>> SHIFT;
      dy = x_i >>> SHIFT;
      // Rotate toward the positive x axis; the arithmetic shift floors.
      if (!y_i[epbf_pkg::CX_W-1]) begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + epbf_pkg::ATAN_TURNS[SHIFT];
      end else begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - epbf_pkg::ATAN_TURNS[SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

>>> design/epbf_box_setup.sv
`timescale 1ns / 1ps
module epbf_box_setup #(
   parameter int W2_W = 23
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [epbf_pkg::BOX_W-1:0]    left_mag,
   input  logic [epbf_pkg::BOX_W-1:0]    span,
   input  logic [epbf_pkg::BOX_W-1:0]    right,
   input  logic [W2_W-1:0]               width2,
   output epbf_pkg::box_rem_type         rem,
   output logic                          busy
);

   localparam int BW = epbf_pkg::BOX_W;
   localparam int CW = W2_W + epbf_pkg::MOD_STEPS;
   localparam int CNT_W = $clog2(epbf_pkg::MOD_STEPS);

   logic load_ff, run_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [BW-1:0] ra_ff, rb_ff, rc_ff;
   logic [BW-1:0] ra_in, rb_in, rc_in;

   always_comb begin
      logic [CW-1:0] d;
      d = CW'(width2) << cnt_ff;
      ra_in = (CW'(ra_ff) >= d) ? ra_ff - d[BW-1:0] : ra_ff;
      rb_in = (CW'(rb_ff) >= d) ? rb_ff - d[BW-1:0] : rb_ff;
      rc_in = (CW'(rc_ff) >= d) ? rc_ff - d[BW-1:0] : rc_ff;
   end

   // A write restarts the pass; the operands are loaded in the next cycle,
   // once the written register holds its new value.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b1;
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         load_ff <= 1'b1;
         run_ff  <= 1'b0;
      end else if (load_ff) begin
         load_ff <= 1'b0;
         run_ff  <= 1'b1;
         cnt_ff  <= CNT_W'(epbf_pkg::MOD_STEPS - 1);
      end else if (run_ff) begin
         if (cnt_ff == '0) begin
            run_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_ff) begin
         ra_ff <= left_mag;
         rb_ff <= span;
         rc_ff <= right;
      end else if (run_ff) begin
         ra_ff <= ra_in;
         rb_ff <= rb_in;
         rc_ff <= rc_in;
      end
   end

   assign rem.left_mag = ra_ff;
   assign rem.span     = rb_ff;
   assign rem.right    = rc_ff;
   assign busy         = load_ff | run_ff;

endmodule

>>> design/epbf_checker.sv
`timescale 1ns / 1ps
module epbf_checker #(
   parameter int LAT = 59
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [31:0] req_point_x,
   input logic signed [31:0] req_point_y,
   input logic signed [31:0] req_point_z,
   input logic               rsp_strobe,
   input logic               rsp_keep,
   input logic               rsp_in_image,
   input logic [20:0]        rsp_u_pixel,
   input logic [20:0]        rsp_v_pixel,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic signed [31:0] rsp_out_z,
   input logic               csr_write_enable,
   input logic [2:0]         csr_index,
   input logic [21:0]        csr_write_data
);

   // A kept point always lies inside the image.
   a_keep_in_image: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_in_image || !rsp_keep))
      else $error("kept point outside the image");

   // Every result beat answers a point taken a fixed latency earlier.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result beat without a matching input beat");

   a_point_through: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_out_x == $past(req_point_x, LAT)) &&
                     (rsp_out_y == $past(req_point_y, LAT)) &&
                     (rsp_out_z == $past(req_point_z, LAT)))
      else $error("passed-through point does not match its input beat");

   // A register write recomputes the box edges before the next point.
   a_busy_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> busy)
      else $error("not busy after a register write");

endmodule

bind equirect_point_box_filter_unit epbf_checker #(.LAT(41 + CORDIC_STAGES)) u_checker (.*);
